FILE: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Transaction structs, operation codes and the internal command format
// passed from the command front end to the execution back end.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int unsigned DEFAULT_QUEUE_DEPTH = 1024;
   localparam int unsigned VALUE_W             = 32;

   localparam logic signed [VALUE_W-1:0] EMPTY_ANSWER = -32'sd1;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_FRONT      = 3'd6,
      OP_BACK       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_PEEK,
      CMD_SIZE,
      CMD_EMPTY
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]                operation;
      logic signed [VALUE_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic                      push_dropped;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      at_back;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

FILE: src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front: command front end
// Accepts request transactions, decodes the operation into a command and
// buffers it in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module dq_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_data,
   output logic            cmd_valid,
   output dq_pkg::cmd_type cmd_data,
   input  logic            cmd_take
);
   import dq_pkg::*;

   localparam int unsigned SLOTS = 2;

   cmd_type    slot_ff [SLOTS];
   cmd_type    decoded;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept;
   logic       take;

   always_comb begin
      decoded.value   = req_data.push_value;
      decoded.at_back = 1'b0;
      decoded.kind    = CMD_SIZE;
      case (op_type'(req_data.operation))
         OP_PUSH_FRONT: decoded.kind = CMD_PUSH;
         OP_PUSH_BACK: begin
            decoded.kind    = CMD_PUSH;
            decoded.at_back = 1'b1;
         end
         OP_POP_FRONT: decoded.kind = CMD_POP;
         OP_POP_BACK: begin
            decoded.kind    = CMD_POP;
            decoded.at_back = 1'b1;
         end
         OP_SIZE:  decoded.kind = CMD_SIZE;
         OP_EMPTY: decoded.kind = CMD_EMPTY;
         OP_FRONT: decoded.kind = CMD_PEEK;
         OP_BACK: begin
            decoded.kind    = CMD_PEEK;
            decoded.at_back = 1'b1;
         end
         default: decoded.kind = CMD_SIZE;
      endcase
   end

   assign req_stall = (fill_ff == 2'(SLOTS));
   assign accept    = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign take      = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept && !take) begin
         fill_in = fill_ff + 2'd1;
      end else if (take && !accept) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (accept) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(SLOTS))
      else $error("command queue overfilled");

   a_fill_up: assert property (@(posedge clock) disable iff (reset)
      accept && !take |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("accepted transaction not counted");

   a_fill_down: assert property (@(posedge clock) disable iff (reset)
      take && !accept |=> fill_ff == $past(fill_ff) - 2'd1)
      else $error("taken command not released");
`endif

endmodule

FILE: src/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back: command execution back end
// Holds the ring pointers and entry count, drives the entry RAM and
// registers each result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module dq_back #(
   parameter int unsigned QUEUE_DEPTH = dq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  dq_pkg::cmd_type cmd_data,
   output logic            cmd_take,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [ADDR_W-1:0] RING_LAST = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  front_ff, front_in;
   logic [ADDR_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]  front_prev, front_next, back_prev, back_next;
   logic               is_empty, is_full;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == FULL_COUNT);
   assign front_prev = (front_ff == '0) ? RING_LAST : front_ff - ADDR_W'(1);
   assign front_next = (front_ff == RING_LAST) ? '0 : front_ff + ADDR_W'(1);
   assign back_prev  = (back_ff == '0) ? RING_LAST : back_ff - ADDR_W'(1);
   assign back_next  = (back_ff == RING_LAST) ? '0 : back_ff + ADDR_W'(1);

   // take a command only when the result register is free or draining
   assign cmd_take = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = back_ff;
      ram_raddr    = front_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_take) begin
               case (cmd_data.kind)
                  CMD_PUSH: begin
                     if (is_full) begin
                        rsp_valid_in             = 1'b1;
                        rsp_data_in.result_value = '0;
                        rsp_data_in.push_dropped = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (cmd_data.at_back) begin
                           ram_waddr = back_ff;
                           back_in   = back_next;
                        end else begin
                           ram_waddr = front_prev;
                           front_in  = front_prev;
                        end
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (is_empty) begin
                        rsp_valid_in             = 1'b1;
                        rsp_data_in.result_value = EMPTY_ANSWER;
                        rsp_data_in.push_dropped = 1'b0;
                     end else begin
                        state_in  = S_READ;
                        ram_raddr = cmd_data.at_back ? back_prev : front_ff;
                        if (cmd_data.kind == CMD_POP) begin
                           count_in = count_ff - CNT_W'(1);
                           if (cmd_data.at_back) begin
                              back_in = back_prev;
                           end else begin
                              front_in = front_next;
                           end
                        end
                     end
                  end
                  CMD_SIZE: begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.result_value = {{(VALUE_W - CNT_W){1'b0}}, count_ff};
                     rsp_data_in.push_dropped = 1'b0;
                  end
                  CMD_EMPTY: begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.result_value = {{(VALUE_W - 1){1'b0}}, is_empty};
                     rsp_data_in.push_dropped = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               endcase
            end
         end
         S_READ: begin
            // RAM data lands now; result register is known to be free
            state_in                 = S_IDLE;
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_value = ram_rdata;
            rsp_data_in.push_dropped = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_data.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds queue depth");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !rsp_valid_ff)
      else $error("read data arrives while result register is occupied");

   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> front_ff == back_ff)
      else $error("pointers disagree on an empty queue");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      cmd_take && cmd_data.kind == CMD_PUSH && !is_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted push not counted");
`endif

endmodule

FILE: src/double_ended_queue.sv
// Size, empty, empty-queue pops and peeks, and full-queue pushes pass the command
// queue and result register; pops and peeks that read the store also pass the
// registered RAM read port. Throughput: one command per cycle while the receiver
// does not stall; a pop or peek of a non-empty queue holds the back end in S_READ.
// Reset clears the pointers, entry count and both queues of transactions;
// the entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed 32-bit values
// A decoding front end feeds a two-entry command queue; the back end
// executes commands against a ring store with front and back pointers.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int unsigned QUEUE_DEPTH = dq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   dq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for double_ended_queue
// Pushes, pops, peeks and queries go in through a queue-fed driver. A shadow
// ring store tracks what the queue should hold. A monitor checks every result
// against the oldest predicted one. Runs cover the empty queue, a deep fill
// from both ends, and pointer wrap at both ends, under random gaps, random
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import dq_pkg::*;

   localparam int unsigned DEPTH            = DEFAULT_QUEUE_DEPTH;
   localparam int unsigned SHADOW_AW        = $clog2(DEPTH);
   localparam int unsigned LONG_HOLD_AT     = 290;
   localparam int unsigned LONG_HOLD_CYCLES = 250;
   localparam int unsigned WATCHDOG_LIMIT   = 3000;
   localparam int unsigned TAIL_CYCLES      = 20;
   localparam int unsigned MAX_PRINTED      = 50;

   typedef struct {
      req_type     cmd;
      int unsigned gap_before;
      bit          wait_drain;
   } pending_cmd_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the queue contents
   logic [VALUE_W-1:0]   shadow_mem [DEPTH];
   logic [SHADOW_AW-1:0] shadow_head  = '0;
   logic [SHADOW_AW-1:0] shadow_tail  = '0;
   int unsigned          shadow_count = 0;

   rsp_type         expected_rsp_q [$];
   pending_cmd_type pending_cmds [$];

   int unsigned cmds_accepted = 0;
   int unsigned results_due   = 0;
   int unsigned results_seen  = 0;
   int unsigned cmds_total    = 0;
   int unsigned error_count   = 0;
   int unsigned quiet_cycles  = 0;
   bit          long_hold_done = 1'b0;

   double_ended_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [SHADOW_AW-1:0] ring_fwd(input logic [SHADOW_AW-1:0] p);
      return (p == SHADOW_AW'(DEPTH - 1)) ? '0 : p + SHADOW_AW'(1);
   endfunction

   function automatic logic [SHADOW_AW-1:0] ring_back(input logic [SHADOW_AW-1:0] p);
      return (p == '0) ? SHADOW_AW'(DEPTH - 1) : p - SHADOW_AW'(1);
   endfunction

   // Update the shadow queue for one command and queue its result, if any.
   task automatic deque_apply(input req_type cmd, output int unsigned n_rsp);
      rsp_type r;
      bit      was_empty;
      r.result_value = '0;
      r.push_dropped = 1'b0;
      n_rsp = 1;
      was_empty = (shadow_count == 0);
      case (op_type'(cmd.operation))
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               r.push_dropped = 1'b1;
            end else begin
               if (op_type'(cmd.operation) == OP_PUSH_FRONT) begin
                  shadow_head = ring_back(shadow_head);
                  shadow_mem[shadow_head] = cmd.push_value;
               end else begin
                  shadow_mem[shadow_tail] = cmd.push_value;
                  shadow_tail = ring_fwd(shadow_tail);
               end
               shadow_count++;
               n_rsp = 0;
            end
         end
         OP_POP_FRONT: begin
            if (was_empty) begin
               r.result_value = EMPTY_ANSWER;
            end else begin
               r.result_value = shadow_mem[shadow_head];
               shadow_head = ring_fwd(shadow_head);
               shadow_count--;
            end
         end
         OP_POP_BACK: begin
            if (was_empty) begin
               r.result_value = EMPTY_ANSWER;
            end else begin
               shadow_tail = ring_back(shadow_tail);
               r.result_value = shadow_mem[shadow_tail];
               shadow_count--;
            end
         end
         OP_SIZE:  r.result_value = shadow_count;
         OP_EMPTY: r.result_value = was_empty ? 1 : 0;
         OP_FRONT: r.result_value = was_empty ? EMPTY_ANSWER : shadow_mem[shadow_head];
         default:  r.result_value = was_empty ? EMPTY_ANSWER
                                              : shadow_mem[ring_back(shadow_tail)];
      endcase
      if (n_rsp != 0)
         expected_rsp_q = {expected_rsp_q, r};
   endtask

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int unsigned idle_len(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_op(input int unsigned push_pct, input int unsigned pop_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         return op_type'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
      if (r < push_pct + pop_pct)
         return op_type'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
      return op_type'($urandom_range(OP_SIZE, OP_BACK));
   endfunction

   task automatic add_cmd(input op_type op, input logic [VALUE_W-1:0] val,
                          input int unsigned gap, input bit drain);
      pending_cmd_type item;
      item.cmd.operation  = op;
      item.cmd.push_value = val;
      item.gap_before     = gap;
      item.wait_drain     = drain;
      pending_cmds = {pending_cmds, item};
      cmds_total++;
   endtask

   // Driver: present pending commands, hold while stalled.
   always @(posedge clock) begin : tx_side
      int unsigned added;
      added = 0;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            deque_apply(req_data, added);
            cmds_accepted <= cmds_accepted + 1;
            results_due   <= results_due + added;
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_cmds[0].wait_drain && results_due + added != results_seen) begin
               req_valid <= 1'b0;
            end else if (pending_cmds[0].gap_before > 0) begin
               pending_cmds[0].gap_before = pending_cmds[0].gap_before - 1;
               req_valid <= 1'b0;
            end else begin
               req_data  <= pending_cmds[0].cmd;
               req_valid <= 1'b1;
               pending_cmds.delete(0);
            end
         end
      end
   end

   // Monitor: check each result transaction, drive random stall.
   always @(posedge clock) begin : rx_side
      rsp_type     want_rsp;
      int unsigned stall_left;
      int unsigned hold_left;
      bit          rx_quiet;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result value=%0d dropped=%0b",
                                         rsp_data.result_value, rsp_data.push_dropped));
            end else begin
               want_rsp = expected_rsp_q[0];
               expected_rsp_q.delete(0);
               if (rsp_data.result_value !== want_rsp.result_value)
                  report_mismatch($sformatf("result_value got %0d want %0d",
                                            rsp_data.result_value, want_rsp.result_value));
               if (rsp_data.push_dropped !== want_rsp.push_dropped)
                  report_mismatch($sformatf("push_dropped got %0b want %0b",
                                            rsp_data.push_dropped, want_rsp.push_dropped));
            end
         end
         rx_quiet = ((cmds_accepted / 300) % 4 == 2);
         // hold off long enough to back up the whole pipeline
         if (!long_hold_done && cmds_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_len(rx_quiet);
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0)
               stall_left--;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned i;
      op_type      op;

      // directed: empty queue, extreme values at both ends, back to empty
      add_cmd(OP_POP_FRONT, pick_value(), 0, 1'b0);
      add_cmd(OP_POP_BACK,  pick_value(), 0, 1'b0);
      add_cmd(OP_FRONT,     pick_value(), 1, 1'b0);
      add_cmd(OP_BACK,      pick_value(), 0, 1'b0);
      add_cmd(OP_SIZE,      32'hFFFF_FFFF, 0, 1'b0);
      add_cmd(OP_EMPTY,     32'h0, 2, 1'b0);
      add_cmd(OP_PUSH_BACK,  32'h7FFF_FFFF, 0, 1'b0);
      add_cmd(OP_PUSH_FRONT, 32'h8000_0000, 0, 1'b0);
      add_cmd(OP_PUSH_BACK,  32'hFFFF_FFFF, 0, 1'b0);
      add_cmd(OP_PUSH_FRONT, 32'h0000_0000, 0, 1'b0);
      add_cmd(OP_SIZE,  pick_value(), 0, 1'b0);
      add_cmd(OP_EMPTY, pick_value(), 0, 1'b0);
      add_cmd(OP_FRONT, pick_value(), 0, 1'b0);
      add_cmd(OP_BACK,  pick_value(), 3, 1'b0);
      add_cmd(OP_POP_BACK,  pick_value(), 0, 1'b0);
      add_cmd(OP_POP_FRONT, pick_value(), 0, 1'b0);
      add_cmd(OP_FRONT,     pick_value(), 0, 1'b0);
      add_cmd(OP_BACK,      pick_value(), 0, 1'b0);
      add_cmd(OP_POP_FRONT, pick_value(), 0, 1'b0);
      add_cmd(OP_POP_BACK,  pick_value(), 0, 1'b0);
      add_cmd(OP_POP_FRONT, pick_value(), 0, 1'b0);
      add_cmd(OP_SIZE,      pick_value(), 0, 1'b0);
      add_cmd(OP_EMPTY,     pick_value(), 0, 1'b0);

      // random mix around a shallow fill level
      for (i = 0; i < 250; i++)
         add_cmd(pick_op(35, 30), pick_value(), idle_len(i >= 150), 1'b0);

      // back-to-back queries, with some pops, while the receiver holds off
      for (i = 0; i < 80; i++)
         add_cmd(pick_op(0, 10), pick_value(), 0, 1'b0);

      // pause until drained, then push hard to build a deep fill
      op = pick_op(85, 5);
      add_cmd(op, pick_value(), 0, 1'b1);
      for (i = 0; i < 300; i++)
         add_cmd(pick_op(85, 5), pick_value(), idle_len(i < 200), 1'b0);
      for (i = 0; i < 40; i++)
         add_cmd(pick_op(70, 10), pick_value(), idle_len(1'b0), 1'b0);

      // pause again, then drain with mostly pops
      add_cmd(pick_op(15, 70), pick_value(), 0, 1'b1);
      for (i = 0; i < 150; i++)
         add_cmd(pick_op(15, 70), pick_value(), idle_len(i >= 100), 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (cmds_accepted != cmds_total || results_seen != results_due)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
